FILE: sv/rpb_pkg.sv
// rpb_pkg: shared types and constants for the pixel blend unit
// pixel beat structs, blend mode codes, register indexes and lane control
// no dependencies
`timescale 1ns / 1ps

package rpb_pkg;

  typedef enum logic [2:0] {
    MODE_MUL = 3'd0,
    MODE_SUB = 3'd1,
    MODE_SCR = 3'd2,
    MODE_OVL = 3'd3,
    MODE_ADD = 3'd4,
    MODE_SCL = 3'd5,
    MODE_SEP = 3'd6
  } blend_mode_t;

  localparam logic [1:0] REG_BLEND_MODE     = 2'd0;
  localparam logic [1:0] REG_TARGET_CHANNEL = 2'd1;
  localparam logic [1:0] REG_ADJUST_VALUE   = 2'd2;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_green;
    logic [7:0] bottom_red;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } out_pixel_t;

  typedef struct packed {
    blend_mode_t        mode;
    logic               is_tgt;
    logic signed [8:0]  adjust;
  } lane_ctrl_t;

endpackage

FILE: sv/rgb_pixel_blend_unit.sv
// rgb_pixel_blend_unit: per-pixel blend and channel adjust, top level
// out_valid is start delayed through the vld_r shift register, one pixel accepted every cycle
// busy stays low; results cannot be stalled and appear for one cycle each
// rst_n synchronous active low clears valid bits and config registers to 0
// depends on rpb_pkg and rpb_lane
`timescale 1ns / 1ps

module rgb_pixel_blend_unit
  import rpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_pixel_t  in_pixel,
  output logic       out_valid,
  output out_pixel_t out_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [2:0]        mode_r;
  logic [1:0]        chan_r;
  logic signed [8:0] adjust_r;
  logic [2:0]        vld_r;
  logic [1:0]        tgt;
  logic [7:0]        sep;
  lane_ctrl_t        ctrl_b;
  lane_ctrl_t        ctrl_g;
  lane_ctrl_t        ctrl_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      chan_r   <= '0;
      adjust_r <= '0;
      vld_r    <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start & ~busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLEND_MODE:     mode_r   <= cfg_data[2:0];
          REG_TARGET_CHANNEL: chan_r   <= cfg_data[1:0];
          REG_ADJUST_VALUE:   adjust_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // channel code three behaves as red
  assign tgt = (chan_r == 2'd3) ? CH_RED : chan_r;

  always_comb begin
    case (tgt)
      CH_BLUE:  sep = in_pixel.top_blue;
      CH_GREEN: sep = in_pixel.top_green;
      default:  sep = in_pixel.top_red;
    endcase
  end

  assign ctrl_b = '{mode: blend_mode_t'(mode_r), is_tgt: (tgt == CH_BLUE),  adjust: adjust_r};
  assign ctrl_g = '{mode: blend_mode_t'(mode_r), is_tgt: (tgt == CH_GREEN), adjust: adjust_r};
  assign ctrl_r = '{mode: blend_mode_t'(mode_r), is_tgt: (tgt == CH_RED),   adjust: adjust_r};

  rpb_lane u_lane_b (
    .clk  (clk),
    .ctrl (ctrl_b),
    .a    (in_pixel.top_blue),
    .b    (in_pixel.bottom_blue),
    .sep  (sep),
    .res  (out_pixel.out_blue)
  );

  rpb_lane u_lane_g (
    .clk  (clk),
    .ctrl (ctrl_g),
    .a    (in_pixel.top_green),
    .b    (in_pixel.bottom_green),
    .sep  (sep),
    .res  (out_pixel.out_green)
  );

  rpb_lane u_lane_r (
    .clk  (clk),
    .ctrl (ctrl_r),
    .a    (in_pixel.top_red),
    .b    (in_pixel.bottom_red),
    .sep  (sep),
    .res  (out_pixel.out_red)
  );

  assign out_valid = vld_r[2];

`ifndef SYNTHESIS
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("accepted beat did not come out after three cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##3 !out_valid)
    else $error("result strobe without an accepted beat");

  a_cfg_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == REG_BLEND_MODE |=> mode_r == $past(cfg_data[2:0]))
    else $error("blend mode write not taken");
`endif

endmodule

FILE: sv/rpb_lane.sv
// rpb_lane: three-stage datapath for one colour channel
// product and operand select, reciprocal estimate of /255, correction and select
// depends on rpb_pkg
`timescale 1ns / 1ps

module rpb_lane
  import rpb_pkg::*;
(
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] sep,
  output logic [7:0] res
);

  typedef enum logic [1:0] {
    K_DIV,
    K_DIV_INV,
    K_PASS,
    K_SCALE
  } kind_t;

  // stage 1
  logic [7:0]         x;
  logic [7:0]         y;
  logic               dbl_nxt;
  kind_t              kind_nxt;
  logic [7:0]         alt_nxt;
  logic signed [9:0]  sum;
  logic signed [17:0] sprod;

  logic [15:0]        prod_r;
  logic signed [17:0] sprod_r;
  logic               dbl_r;
  kind_t              kind_r;
  logic [7:0]         alt_r;

  // stage 2
  logic [16:0]        v_nxt;
  logic [25:0]        v257;
  logic [7:0]         alt2_nxt;

  logic [16:0]        v2_r;
  logic [7:0]         qe2_r;
  kind_t              kind2_r;
  logic [7:0]         alt2_r;

  // stage 3
  logic [16:0]        qe255;
  logic [16:0]        rem;
  logic [7:0]         q;
  logic [7:0]         res_nxt;
  logic [7:0]         res_r;

  assign sum   = $signed({2'b00, a}) + $signed({ctrl.adjust[8], ctrl.adjust});
  assign sprod = $signed({1'b0, a}) * ctrl.adjust;

  always_comb begin
    x        = a;
    y        = b;
    dbl_nxt  = 1'b0;
    kind_nxt = K_PASS;
    alt_nxt  = a;
    case (ctrl.mode)
      MODE_MUL: begin
        kind_nxt = K_DIV;
      end
      MODE_SUB: begin
        alt_nxt = (a > b) ? 8'(a - b) : 8'd0;
      end
      MODE_SCR: begin
        x        = ~a;
        y        = ~b;
        kind_nxt = K_DIV_INV;
      end
      MODE_OVL: begin
        dbl_nxt = 1'b1;
        if (b <= 8'd127) begin
          kind_nxt = K_DIV;
        end else begin
          x        = ~a;
          y        = ~b;
          kind_nxt = K_DIV_INV;
        end
      end
      MODE_ADD: begin
        if (ctrl.is_tgt) begin
          if (sum <= 10'sd0) alt_nxt = 8'd0;
          else if (sum >= 10'sd255) alt_nxt = 8'd255;
          else alt_nxt = sum[7:0];
        end
      end
      MODE_SCL: begin
        if (ctrl.is_tgt) kind_nxt = K_SCALE;
      end
      MODE_SEP: begin
        alt_nxt = sep;
      end
      default: begin
        alt_nxt = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r  <= x * y;
    sprod_r <= sprod;
    dbl_r   <= dbl_nxt;
    kind_r  <= kind_nxt;
    alt_r   <= alt_nxt;
  end

  // floor(v/255) estimate: v*257 >> 16, low by at most one
  assign v_nxt = (dbl_r ? {prod_r, 1'b0} : {1'b0, prod_r}) + 17'd127;
  assign v257  = {1'b0, v_nxt, 8'b0} + {9'b0, v_nxt};

  always_comb begin
    alt2_nxt = alt_r;
    if (kind_r == K_SCALE) begin
      if (sprod_r <= 18'sd0) alt2_nxt = 8'd0;
      else if (sprod_r >= 18'sd255) alt2_nxt = 8'd255;
      else alt2_nxt = sprod_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    v2_r    <= v_nxt;
    qe2_r   <= v257[23:16];
    kind2_r <= kind_r;
    alt2_r  <= alt2_nxt;
  end

  assign qe255 = {1'b0, qe2_r, 8'b0} - {9'b0, qe2_r};
  assign rem   = v2_r - qe255;
  assign q     = (rem >= 17'd255) ? 8'(qe2_r + 8'd1) : qe2_r;

  always_comb begin
    case (kind2_r)
      K_DIV:     res_nxt = q;
      K_DIV_INV: res_nxt = ~q;
      default:   res_nxt = alt2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: dv/rpb_blend_checker.sv
// rpb_blend_checker: watches the pixel, result and register channels of the blend unit
// predicts each output pixel from its own copy of the registers and counts mismatches
// depends on rpb_pkg
`timescale 1ns / 1ps

module rpb_blend_checker
  import rpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_pixel_t  in_pixel,
  input  logic       out_valid,
  input  out_pixel_t out_pixel,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [2:0]        mode_reg;
  logic [1:0]        chan_reg;
  logic signed [8:0] adjust_reg;
  out_pixel_t        blended_q [$];

  function automatic int clamp_byte(int v);
    if (v <= 0) return 0;
    if (v >= 255) return 255;
    return v;
  endfunction

  function automatic out_pixel_t blend_pixel(in_pixel_t px);
    int top [3];
    int bot [3];
    int res [3];
    int sel;
    int adj;
    int prod;
    top[0] = px.top_blue;
    top[1] = px.top_green;
    top[2] = px.top_red;
    bot[0] = px.bottom_blue;
    bot[1] = px.bottom_green;
    bot[2] = px.bottom_red;
    res = top;
    // unused channel code falls back to red
    sel = (chan_reg > CH_RED) ? int'(CH_RED) : int'(chan_reg);
    adj = int'(adjust_reg);
    case (mode_reg)
      MODE_MUL: begin
        for (int i = 0; i < 3; i++) res[i] = (2 * top[i] * bot[i] + 255) / 510;
      end
      MODE_SUB: begin
        for (int i = 0; i < 3; i++) res[i] = (top[i] > bot[i]) ? top[i] - bot[i] : 0;
      end
      MODE_SCR: begin
        for (int i = 0; i < 3; i++) begin
          prod = (255 - top[i]) * (255 - bot[i]);
          res[i] = 255 - (2 * prod + 255) / 510;
        end
      end
      MODE_OVL: begin
        for (int i = 0; i < 3; i++) begin
          if (bot[i] <= 127) begin
            res[i] = (4 * top[i] * bot[i] + 255) / 510;
          end else begin
            prod = (255 - top[i]) * (255 - bot[i]);
            res[i] = 255 - (4 * prod + 255) / 510;
          end
        end
      end
      MODE_ADD: res[sel] = clamp_byte(top[sel] + adj);
      MODE_SCL: res[sel] = clamp_byte(top[sel] * adj);
      MODE_SEP: begin
        for (int i = 0; i < 3; i++) res[i] = top[sel];
      end
      default: ;
    endcase
    return {res[0][7:0], res[1][7:0], res[2][7:0]};
  endfunction

  task automatic report_error(string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      report_error($sformatf("%s wrong: expected %0d, got %0d", field, want, got));
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst_n) begin
      mode_reg   <= MODE_MUL;
      chan_reg   <= CH_BLUE;
      adjust_reg <= '0;
      blended_q.delete();
    end else begin
      if (out_valid) begin
        if (blended_q.size() == 0) begin
          report_error($sformatf("result beat with nothing expected: %h", out_pixel));
        end else begin
          want = blended_q.pop_front();
          check_field("out_blue", want.out_blue, out_pixel.out_blue);
          check_field("out_green", want.out_green, out_pixel.out_green);
          check_field("out_red", want.out_red, out_pixel.out_red);
        end
      end
      if (start && !busy) blended_q = {blended_q, blend_pixel(in_pixel)};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLEND_MODE:     mode_reg   <= cfg_data[2:0];
          REG_TARGET_CHANNEL: chan_reg   <= cfg_data[1:0];
          REG_ADJUST_VALUE:   adjust_reg <= cfg_data;
          default: ;
        endcase
      end
    end
    pending = blended_q.size();
  end

endmodule

FILE: dv/rgb_pixel_blend_unit_test.sv
// rgb_pixel_blend_unit_test: stimulus and verdict for the pixel blend unit
// directed corner pixels per mode, then random phases under changing registers
// depends on rpb_pkg, rgb_pixel_blend_unit and rpb_blend_checker
`timescale 1ns / 1ps

module rgb_pixel_blend_unit_test;
  import rpb_pkg::*;

  localparam logic [2:0] MODE_PASS     = 3'd7;
  localparam logic [1:0] CH_BEYOND_RED = 2'd3;
  localparam logic [8:0] ADJ_MAX       = 9'h0ff;
  localparam logic [8:0] ADJ_MIN       = 9'h101;
  localparam logic [8:0] ADJ_FLOOR     = 9'h100;
  localparam logic [8:0] ADJ_NEG_ONE   = 9'h1ff;
  localparam int PHASES       = 26;
  localparam int PHASE_PIXELS = 25;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_pixel_t  in_pixel;
  logic       out_valid;
  out_pixel_t out_pixel;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  int         fail_count;
  int         pending;
  bit         gaps_on;

  rgb_pixel_blend_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rpb_blend_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_pixel_t pix(logic [7:0] tb, logic [7:0] tg, logic [7:0] tr,
                                    logic [7:0] bb, logic [7:0] bg, logic [7:0] br);
    return {tb, tg, tr, bb, bg, br};
  endfunction

  // corner values turn up often so clamps and the overlay split get hit
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [8:0] rand_adjust();
    case ($urandom_range(7))
      0:       return ADJ_MAX;
      1:       return ADJ_MIN;
      2:       return ADJ_FLOOR;
      3:       return '0;
      4:       return ADJ_NEG_ONE;
      5:       return 9'($urandom_range(4));
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(logic [2:0] mode, logic [1:0] chan, logic [8:0] adj);
    write_reg(REG_BLEND_MODE, {6'd0, mode});
    write_reg(REG_TARGET_CHANNEL, {7'd0, chan});
    write_reg(REG_ADJUST_VALUE, adj);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(in_pixel_t px);
    while (gaps_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  // stop feeding and let every outstanding pixel drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic one_shot(logic [2:0] mode, logic [1:0] chan, logic [8:0] adj,
                          in_pixel_t px);
    drain();
    program_regs(mode, chan, adj);
    send_pixel(px);
  endtask

  initial begin
    logic [2:0] mode;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_pixel  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BLEND_MODE;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: multiply
    send_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    one_shot(MODE_SUB, CH_BLUE, '0, pix(8'hff, 8'h00, 8'h80, 8'h00, 8'hff, 8'h80));
    one_shot(MODE_SCR, CH_BLUE, '0, pix(8'h00, 8'hff, 8'h7f, 8'hff, 8'h00, 8'h80));
    one_shot(MODE_OVL, CH_BLUE, '0, pix(8'hc8, 8'hc8, 8'hc8, 8'h7f, 8'h80, 8'hff));
    send_pixel(pix(8'h00, 8'hff, 8'h40, 8'h00, 8'hff, 8'h40));
    one_shot(MODE_ADD, CH_BLUE, ADJ_MAX, pix(8'hff, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56));
    send_pixel(pix(8'h01, 8'h80, 8'h7f, 8'hff, 8'hff, 8'hff));
    one_shot(MODE_ADD, CH_GREEN, ADJ_MIN, pix(8'h10, 8'hfe, 8'h20, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_ADD, CH_RED, ADJ_FLOOR, pix(8'h33, 8'h44, 8'hff, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_SCL, CH_GREEN, ADJ_MAX, pix(8'h05, 8'h00, 8'h07, 8'hff, 8'hff, 8'hff));
    send_pixel(pix(8'h05, 8'h01, 8'h07, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_SCL, CH_RED, ADJ_NEG_ONE, pix(8'h11, 8'h22, 8'h80, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_SCL, CH_BEYOND_RED, 9'd2, pix(8'h80, 8'h80, 8'h70, 8'h01, 8'h02, 8'h03));
    one_shot(MODE_SCL, CH_BLUE, '0, pix(8'hff, 8'h55, 8'haa, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_SEP, CH_GREEN, '0, pix(8'h12, 8'h9a, 8'hfe, 8'h00, 8'h00, 8'h00));
    one_shot(MODE_SEP, CH_BEYOND_RED, '0, pix(8'h12, 8'h9a, 8'hfe, 8'hff, 8'hff, 8'hff));
    one_shot(MODE_PASS, CH_BLUE, ADJ_MAX, pix(8'h01, 8'h80, 8'hfe, 8'hff, 8'h00, 8'h55));

    for (int k = 0; k < PHASES; k++) begin
      mode    = 3'(k % 8);
      gaps_on = !(k >= 12 && k < 16);
      drain();
      program_regs(mode, 2'($urandom_range(3)), rand_adjust());
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(pix(rand_byte(), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte(), rand_byte()));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rpb_pkg.sv
sv/rpb_lane.sv
sv/rgb_pixel_blend_unit.sv
dv/rpb_blend_checker.sv
dv/rgb_pixel_blend_unit_test.sv
